>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/mpsf_pkg.sv
// ----------------------------------------------------------------------------
// mpsf_pkg
// Shared types, constants and header check for the MPEG audio sync finder.
// ----------------------------------------------------------------------------
package mpsf_pkg;

    localparam int unsigned DEF_MIN_FILE_BYTES = 1024;
    localparam int unsigned DEF_SCAN_WINDOW    = 4096;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [7:0]  SYNC_HI_MASK  = 8'hE0;
    localparam logic [7:0]  TAG_CHAR_I    = 8'h49;
    localparam logic [7:0]  TAG_CHAR_D    = 8'h44;
    localparam logic [7:0]  TAG_CHAR_3    = 8'h33;
    localparam logic [31:0] TAG_HDR_BYTES = 32'd10;
    localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_BELOW_MIN = 2'd1,
        STATUS_SHORT     = 2'd2,
        STATUS_NO_FRAME  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic        accepted;
        status_t     status;
        logic [31:0] frame_position;
    } result_t;

    // Frame header check on the first three header bytes.
    function automatic logic header_ok(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2);
        logic ok;
        ok = (b0 == SYNC_BYTE)
          && ((b1 & SYNC_HI_MASK) == SYNC_HI_MASK)
          && (b1[4:3] != 2'b01)     // reserved version
          && (b1[2:1] != 2'b00)     // reserved layer
          && (b2[7:4] != 4'hF)      // bad bitrate index
          && (b2[3:2] != 2'b11);    // reserved sample rate
        return ok;
    endfunction

endpackage

>>> sv/mpsf_in_reg.sv
// ----------------------------------------------------------------------------
// mpsf_in_reg
// Input register: holds one byte transaction until the scan stage takes it.
// ----------------------------------------------------------------------------
module mpsf_in_reg
    import mpsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  byte_item_t s_item,
    input  logic       take,
    output logic       item_valid,
    output byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       load;

    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/mpsf_scan.sv
// ----------------------------------------------------------------------------
// mpsf_scan
// Per-file scan state: tag parse, window check, header match, final status.
// ----------------------------------------------------------------------------
module mpsf_scan
    import mpsf_pkg::*;
#(
    parameter int unsigned MIN_FILE_BYTES = DEF_MIN_FILE_BYTES,
    parameter int unsigned SCAN_WINDOW    = DEF_SCAN_WINDOW
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  byte_item_t item,
    output result_t    result
);

    logic [31:0] cnt_reg,       cnt_next;
    logic [23:0] recent_reg,    recent_next;
    logic        tag_reg,       tag_next;
    logic [29:0] start_reg,     start_next;
    logic        found_reg,     found_next;
    logic [31:0] found_pos_reg, found_pos_next;

    logic [32:0] q_ext;
    logic [32:0] win_lo;
    logic [32:0] win_end;
    logic        hit;
    logic [29:0] tag_bits;
    logic [29:0] start_or;
    status_t     status;

    assign q_ext   = {1'b0, cnt_reg};
    assign win_lo  = {3'b0, start_reg} + 33'd3;
    assign win_end = {3'b0, start_reg} + 33'(SCAN_WINDOW);

    // Header at q-3 .. q, its first three bytes held in recent_reg.
    assign hit = (cnt_reg >= 32'd3) && !found_reg
              && (!tag_reg || (cnt_reg >= TAG_HDR_BYTES))
              && (q_ext >= win_lo) && (q_ext < win_end)
              && header_ok(recent_reg[23:16], recent_reg[15:8], recent_reg[7:0]);

    // Tag size bytes, full 8 bits each, ORed in place.
    always_comb begin
        case (cnt_reg[1:0])
            2'b10:   tag_bits = 30'(item.data_byte) << 21;
            2'b11:   tag_bits = 30'(item.data_byte) << 14;
            2'b00:   tag_bits = 30'(item.data_byte) << 7;
            default: tag_bits = 30'(item.data_byte);
        endcase
    end

    assign start_or = start_reg | tag_bits;

    always_comb begin
        found_next     = found_reg || hit;
        found_pos_next = hit ? (cnt_reg - 32'd3) : found_pos_reg;
        tag_next       = tag_reg
                      || ((cnt_reg == 32'd2) && (recent_reg[15:8] == TAG_CHAR_I)
                          && (recent_reg[7:0] == TAG_CHAR_D) && (item.data_byte == TAG_CHAR_3));
        start_next     = start_reg;
        if (tag_reg && (cnt_reg inside {[32'd6:32'd9]})) begin
            start_next = (cnt_reg == 32'd9) ? (start_or + 30'd10) : start_or;
        end
        recent_next = {recent_reg[15:0], item.data_byte};
        cnt_next    = (cnt_reg == CNT_MAX) ? cnt_reg : (cnt_reg + 32'd1);
    end

    always_comb begin
        if ({1'b0, cnt_next} < 33'(MIN_FILE_BYTES)) begin
            status = STATUS_BELOW_MIN;
        end else if (cnt_next < TAG_HDR_BYTES) begin
            status = STATUS_SHORT;
        end else if (!found_next) begin
            status = STATUS_NO_FRAME;
        end else begin
            status = STATUS_VALID;
        end
        result.accepted       = (status == STATUS_VALID);
        result.status         = status;
        result.frame_position = (status == STATUS_VALID) ? found_pos_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            cnt_reg       <= 32'd0;
            recent_reg    <= 24'd0;
            tag_reg       <= 1'b0;
            start_reg     <= 30'd0;
            found_reg     <= 1'b0;
            found_pos_reg <= 32'd0;
        end else if (step) begin
            cnt_reg       <= cnt_next;
            recent_reg    <= recent_next;
            tag_reg       <= tag_next;
            start_reg     <= start_next;
            found_reg     <= found_next;
            found_pos_reg <= found_pos_next;
        end
    end

endmodule

>>> sv/mpsf_out_reg.sv
// ----------------------------------------------------------------------------
// mpsf_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module mpsf_out_reg
    import mpsf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

>>> sv/mpeg_audio_sync_finder_top.sv
// ----------------------------------------------------------------------------
// mpeg_audio_sync_finder_top: MPEG audio frame sync finder over a byte stream.
// Throughput one byte per cycle; a final byte waits only while an untaken result is held.
// Path: the final byte passes the input register, then loads the result register;
// m_valid rises in the cycle after the final byte leaves the input register.
// Reset: aresetn synchronous active low; clears valids and all scan state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpeg_audio_sync_finder_top
    import mpsf_pkg::*;
#(
    parameter int unsigned MIN_FILE_BYTES = DEF_MIN_FILE_BYTES,
    parameter int unsigned SCAN_WINDOW    = DEF_SCAN_WINDOW
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result channel, one transaction per file
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [1:0]  m_status,
    output logic [31:0] m_frame_position
);

    byte_item_t s_item;
    byte_item_t item;
    logic       item_valid;
    logic       advance;
    result_t    scan_result;
    result_t    m_result;

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    // Stage 1: input register parts the source from the scan logic.
    mpsf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // A non-final byte never produces a result, so it always moves on.
    // The final byte moves on once the result register is free or draining.
    assign advance = item_valid && (!item.last_byte || !m_valid || m_ready);

    // Stage 2: scan state update and status, single pass per byte.
    mpsf_scan #(
        .MIN_FILE_BYTES (MIN_FILE_BYTES),
        .SCAN_WINDOW    (SCAN_WINDOW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .result  (scan_result)
    );

    // Result register: loaded only on the final byte of a file.
    mpsf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && item.last_byte),
        .result   (scan_result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_accepted       = m_result.accepted;
    assign m_status         = m_result.status;
    assign m_frame_position = m_result.frame_position;

    // accepted flag agrees with status on every result transaction
    `ASSERT_IMP(a_accept_status, aclk, aresetn, m_valid, m_accepted == (m_status == STATUS_VALID))
    // a rejected file reports position zero
    `ASSERT_IMP(a_pos_zero, aclk, aresetn, m_valid && !m_accepted, m_frame_position == 32'd0)
    // a held byte stalls only as a final byte behind an untaken result
    `ASSERT_IMP(a_stall_cause, aclk, aresetn, item_valid && !advance,
                item.last_byte && m_valid && !m_ready)
    // a final byte that moves on shows up as a result next cycle
    `ASSERT_IMP_NEXT(a_last_loads, aclk, aresetn, advance && item.last_byte, m_valid)

endmodule

>>> sim/tb_mpeg_audio_sync_finder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mpeg_audio_sync_finder_top
// Self-checking bench for the MPEG audio sync finder. Files are streamed in
// one byte per transaction; a local predictor of the scan rules works out the
// verdict for each file, and every result transaction is compared against it.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_sync_finder_top;

    import mpsf_pkg::*;

    localparam int unsigned MIN_BYTES = DEF_MIN_FILE_BYTES;
    localparam int unsigned WINDOW    = DEF_SCAN_WINDOW;

    // header field codes that disqualify a sync pattern
    localparam logic [1:0] VERSION_RESERVED = 2'b01;
    localparam logic [1:0] LAYER_RESERVED   = 2'b00;
    localparam logic [3:0] BITRATE_BAD      = 4'hF;
    localparam logic [1:0] FREQ_RESERVED    = 2'b11;

    typedef enum int {
        HDR_GOOD, HDR_BAD_SYNC, HDR_BAD_HIGH, HDR_BAD_VERSION,
        HDR_BAD_LAYER, HDR_BAD_BITRATE, HDR_BAD_FREQ
    } hdr_kind_e;

    typedef enum int { FILL_ZERO, FILL_NOISE, FILL_SYNC_RICH } fill_e;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_accepted;
    logic [1:0]  m_status;
    logic [31:0] m_frame_position;

    mpeg_audio_sync_finder_top #(
        .MIN_FILE_BYTES (MIN_BYTES),
        .SCAN_WINDOW    (WINDOW)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_status         (m_status),
        .m_frame_position (m_frame_position)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    result_t     expected_verdicts[$];   // one entry per file in flight
    logic [7:0]  file_buf[$];            // file being built by a test
    int          errors        = 0;
    int          files_sent    = 0;
    int          bytes_sent    = 0;
    int          verdicts_seen = 0;
    int          status_count[4] = '{0, 0, 0, 0};

    // sender pacing
    bit          idle_on    = 1'b1;
    int          burst_left = 0;

    // receiver pacing; hold_req asks the receiver for a long hold-off
    bit          stall_on  = 1'b1;
    int          hold_req  = 0;

    // predictor copy of the scan state
    logic [31:0] fb_count;
    logic [23:0] fb_recent;
    logic        fb_tag;
    logic [29:0] fb_start;
    logic        fb_found;
    logic [31:0] fb_pos;

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Worst case is far below this limit: under 3k bytes, plus idle gaps and stalls.
    initial begin
        #(1_000_000);
        $display("[mpeg_audio_sync_finder_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic sync_header_valid(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2);
        return (b0 == SYNC_BYTE) && (b1[7:5] == 3'b111)
            && (b1[4:3] != VERSION_RESERVED) && (b1[2:1] != LAYER_RESERVED)
            && (b2[7:4] != BITRATE_BAD) && (b2[3:2] != FREQ_RESERVED);
    endfunction

    function automatic void clear_file_state();
        fb_count  = '0;
        fb_recent = '0;
        fb_tag    = 1'b0;
        fb_start  = '0;
        fb_found  = 1'b0;
        fb_pos    = '0;
    endfunction

    // Advances the scan by one byte; on the final byte queues the verdict.
    function automatic void predict_verdict(input logic [7:0] b, input logic last);
        logic [31:0]     pos;
        longint unsigned win_end;
        logic [31:0]     tag_acc;
        int              sh;
        status_t         st;
        result_t         v;
        pos = fb_count;

        // header whose fourth byte is this one starts at pos-3
        if (pos >= 3 && !fb_found && (!fb_tag || pos >= TAG_HDR_BYTES)) begin
            win_end = longint'(fb_start) + longint'(WINDOW);
            if ((pos - 3) >= {2'b00, fb_start} && longint'(pos) < win_end &&
                sync_header_valid(fb_recent[23:16], fb_recent[15:8], fb_recent[7:0])) begin
                fb_found = 1'b1;
                fb_pos   = pos - 3;
            end
        end

        if (pos == 2 && fb_recent[15:0] == {TAG_CHAR_I, TAG_CHAR_D} && b == TAG_CHAR_3)
            fb_tag = 1'b1;

        // tag size: full bytes, not syncsafe-masked
        if (fb_tag && pos >= 6 && pos <= 9) begin
            case (pos)
                6:       sh = 21;
                7:       sh = 14;
                8:       sh = 7;
                default: sh = 0;
            endcase
            tag_acc = {2'b00, fb_start} | (32'(b) << sh);
            if (pos == 9)
                tag_acc = tag_acc + TAG_HDR_BYTES;
            fb_start = tag_acc[29:0];
        end

        fb_recent = {fb_recent[15:0], b};
        if (fb_count != CNT_MAX)
            fb_count = fb_count + 1;

        if (last) begin
            if (fb_count < MIN_BYTES)          st = STATUS_BELOW_MIN;
            else if (fb_count < TAG_HDR_BYTES) st = STATUS_SHORT;
            else if (!fb_found)                st = STATUS_NO_FRAME;
            else                               st = STATUS_VALID;
            v.accepted       = (st == STATUS_VALID);
            v.status         = st;
            v.frame_position = (st == STATUS_VALID) ? fb_pos : 32'd0;
            expected_verdicts.push_back(v);
            clear_file_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = idle_on ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        predict_verdict(b, last);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
        files_sent++;
    endtask

    // Drop valid and wait until every verdict has come back.
    task automatic drain_verdicts();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    task automatic new_file(input int len, input fill_e fill);
        logic [7:0] b;
        file_buf.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO:  b = 8'h00;
                FILL_NOISE: b = 8'($urandom);
                default: begin
                    // lots of sync-looking bytes so random headers turn up
                    case ($urandom_range(0, 3))
                        0:       b = SYNC_BYTE;
                        1:       b = SYNC_HI_MASK | 8'($urandom_range(0, 31));
                        default: b = 8'($urandom);
                    endcase
                end
            endcase
            file_buf.push_back(b);
        end
    endtask

    task automatic put_id3(input logic [7:0] s6, input logic [7:0] s7,
                           input logic [7:0] s8, input logic [7:0] s9);
        if (file_buf.size() >= TAG_HDR_BYTES) begin
            file_buf[0] = TAG_CHAR_I;
            file_buf[1] = TAG_CHAR_D;
            file_buf[2] = TAG_CHAR_3;
            file_buf[6] = s6;
            file_buf[7] = s7;
            file_buf[8] = s8;
            file_buf[9] = s9;
        end
    endtask

    // Writes a four-byte header at the given offset; bad kinds break one field.
    task automatic put_header(input int at, input hdr_kind_e kind);
        logic [7:0] h[4];
        logic [1:0] ver;
        logic [1:0] layer;
        logic [3:0] rate;
        logic [1:0] freq;
        do ver = 2'($urandom_range(0, 3)); while (ver == VERSION_RESERVED);
        layer = 2'($urandom_range(1, 3));
        rate  = 4'($urandom_range(0, 14));
        freq  = 2'($urandom_range(0, 2));
        case (kind)
            HDR_BAD_VERSION: ver   = VERSION_RESERVED;
            HDR_BAD_LAYER:   layer = LAYER_RESERVED;
            HDR_BAD_BITRATE: rate  = BITRATE_BAD;
            HDR_BAD_FREQ:    freq  = FREQ_RESERVED;
            default: ;
        endcase
        h[0] = SYNC_BYTE;
        h[1] = {3'b111, ver, layer, 1'($urandom)};
        h[2] = {rate, freq, 2'($urandom)};
        h[3] = 8'($urandom);
        if (kind == HDR_BAD_SYNC)
            h[0] = 8'($urandom_range(0, 254));
        if (kind == HDR_BAD_HIGH)
            h[1][7:5] = 3'($urandom_range(0, 6));
        for (int i = 0; i < 4; i++)
            if (at + i < file_buf.size())
                file_buf[at + i] = h[i];
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready/stall runs while stall_on, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin
        int  hold_left;
        int  run_left;
        bit  run_high;
        hold_left = 0;
        run_left  = 0;
        run_high  = 1'b1;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!stall_on) begin
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_high = ~run_high;
                    run_left = run_high ? $urandom_range(1, 20) : $urandom_range(1, 6);
                end
                m_ready <= run_high;
                run_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transaction against the oldest verdict
    // ------------------------------------------------------------------
    result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result with nothing pending: accepted=%0b status=%0d pos=%0d",
                         $time, m_accepted, m_status, m_frame_position);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                verdicts_seen++;
                status_count[m_status]++;
                if (m_accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch: expected %0b actual %0b",
                             $time, want.accepted, m_accepted);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_frame_position !== want.frame_position) begin
                    $display("%0t: frame_position mismatch: expected %0d actual %0d",
                             $time, want.frame_position, m_frame_position);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Files under the size limit; size check takes priority over the rest.
    task automatic test_size_limits();
        new_file(1, FILL_ZERO);
        file_buf[0] = SYNC_BYTE;
        send_file();
        new_file(3, FILL_ZERO);
        file_buf[0] = TAG_CHAR_I;
        file_buf[1] = TAG_CHAR_D;
        file_buf[2] = TAG_CHAR_3;
        send_file();
        new_file(TAG_HDR_BYTES, FILL_ZERO);
        put_header(0, HDR_GOOD);
        send_file();
        new_file(MIN_BYTES - 1, FILL_ZERO);
        put_header(0, HDR_GOOD);
        send_file();
    endtask

    // One file of exactly the minimum size: the tag moves the scan start to
    // 138 (bit 7 of the low size byte counts), headers before it are skipped,
    // each broken field is rejected, and the match ends on the final byte.
    task automatic test_header_and_tag();
        new_file(MIN_BYTES, FILL_ZERO);
        put_id3(8'h00, 8'h00, 8'h00, 8'h80);
        put_header(100, HDR_GOOD);
        put_header(137, HDR_GOOD);
        for (int k = 1; k <= 6; k++)
            put_header(100 + k * 100, hdr_kind_e'(k));
        put_header(MIN_BYTES - 4, HDR_GOOD);
        send_file();
    endtask

    // Receiver holds off while many tiny files arrive: the block must stall.
    task automatic test_back_pressure();
        drain_verdicts();
        idle_on  = 1'b0;
        hold_req = 400;
        repeat (30) begin
            new_file($urandom_range(1, 4), FILL_SYNC_RICH);
            send_file();
        end
        idle_on = 1'b1;
    endtask

    // Random short files, some tagged, some with planted headers.
    task automatic test_random_files();
        int len;
        int nhdr;
        repeat (16) begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            len = $urandom_range(1, 48);
            new_file(len, fill_e'($urandom_range(0, 2)));
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 2) == 0)
                    put_id3(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    put_id3(8'h00, 8'h00, 8'h00, 8'($urandom_range(0, 40)));
            end
            nhdr = $urandom_range(0, 3);
            repeat (nhdr) begin
                if ($urandom_range(0, 1) == 0)
                    put_header($urandom_range(0, len - 1), HDR_GOOD);
                else
                    put_header($urandom_range(0, len - 1), hdr_kind_e'($urandom_range(1, 6)));
            end
            send_file();
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = 8'h00;
        s_last_byte = 1'b0;
        clear_file_state();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_size_limits();
        test_header_and_tag();
        test_back_pressure();
        test_random_files();

        drain_verdicts();
        // give any stray result time to show
        repeat (16) @(posedge aclk);

        $display("Streamed %0d files, %0d bytes; %0d verdicts checked", files_sent,
                 bytes_sent, verdicts_seen);
        $display("Verdicts: %0d valid, %0d below minimum, %0d too short, %0d no frame",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        if (errors == 0)
            $display("[mpeg_audio_sync_finder_top] OK");
        else
            $display("[mpeg_audio_sync_finder_top] ERROR");
        $finish;
    end

endmodule
